[sv/itdt_pkg.sv]
// ----------------------------------------------------------------------------
// itdt_pkg
// Types, constants and the binary-to-BCD step function shared by the
// integer to decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itdt_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned STEPS    = 8;
    localparam int unsigned STAGES   = WORD_W / STEPS;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              is_signed;
    } itdt_in_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } itdt_out_t;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [WORD_W-1:0] bin;
        logic              neg;
    } itdt_dd_t;

    // Eight shift-and-add-three steps of the double dabble conversion.
    function automatic itdt_dd_t dabble_steps(input itdt_dd_t d);
        itdt_dd_t r;
        r = d;
        for (int s = 0; s < STEPS; s++) begin
            for (int k = 0; k < DIGITS; k++) begin
                if (r.bcd[4*k +: 4] >= 4'd5) begin
                    r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/itdt_stage.sv]
// ----------------------------------------------------------------------------
// itdt_stage
// One pipeline stage of the binary-to-BCD conversion: eight steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itdt_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire itdt_pkg::itdt_dd_t in_data,
    output logic                    out_valid,
    output itdt_pkg::itdt_dd_t      out_data
);
    import itdt_pkg::*;

    logic     valid_reg;
    itdt_dd_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= dabble_steps(in_data);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[sv/itdt_serial.sv]
// ----------------------------------------------------------------------------
// itdt_serial
// Takes a converted number and emits its text one character per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itdt_serial (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire itdt_pkg::itdt_dd_t in_data,
    output logic                    ready,
    output logic                    strobe,
    output itdt_pkg::itdt_out_t     result
);
    import itdt_pkg::*;

    logic             act_reg, act_next;
    logic             sign_reg, sign_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [BCD_W-1:0] bcd_reg;
    logic             strobe_reg, strobe_next;
    itdt_out_t        result_reg, result_next;
    logic             finishing;
    logic             take;
    logic [IDX_W-1:0] top_idx;

    // Index of the most significant nonzero digit; zero still gives one digit.
    always_comb
    begin
        top_idx = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (in_data.bcd[4*k +: 4] != 4'd0) begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign finishing = act_reg && !sign_reg && (idx_reg == '0);
    assign ready     = !act_reg || finishing;
    assign take      = in_valid && ready;

    always_comb
    begin
        act_next    = act_reg;
        sign_next   = sign_reg;
        idx_next    = idx_reg;
        strobe_next = act_reg;
        result_next = result_reg;
        if (act_reg)
        begin
            if (sign_reg)
            begin
                result_next.character = CHAR_MINUS;
                result_next.last      = 1'b0;
                sign_next             = 1'b0;
            end
            else
            begin
                result_next.character = CHAR_ZERO + {4'd0, bcd_reg[4*idx_reg +: 4]};
                result_next.last      = (idx_reg == '0);
                idx_next              = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    act_next = 1'b0;
                end
            end
        end
        if (take)
        begin
            act_next  = 1'b1;
            sign_next = in_data.neg;
            idx_next  = top_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            act_reg    <= act_next;
            sign_reg   <= sign_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (take)
        begin
            bcd_reg <= in_data.bcd;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (idx_reg < IDX_W'(DIGITS)))
        else $error("digit index out of range");
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.character == CHAR_MINUS) |-> !result.last)
        else $error("minus sign marked as last");
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.character == CHAR_MINUS) |=> strobe)
        else $error("minus sign not followed by a digit");
    a_take_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && !finishing) |-> !take)
        else $error("number loaded while text still in progress");

endmodule

`default_nettype wire

[sv/integer_to_decimal_text.sv]
// ----------------------------------------------------------------------------
// integer_to_decimal_text
// Converts a 32-bit signed or unsigned word to decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage: drive request and raise start; the word is taken at a rising edge
// where start is high and busy is low. Characters come out on result, most
// significant first, each valid for one cycle while strobe is high; the
// final character has result.last set. Negative signed values lead with '-'.
// Path: the first character passes the sign-handling register, four
// conversion stages of eight BCD steps each, the load into the character
// serializer, then the output register.
// Throughput: one character per cycle; a word gives 1 to 11 characters,
// and the conversion pipeline holds up to five more words in flight;
// busy rises only when all of it is full.
// Reset clears all valid bits and the serializer; no word is in flight after
// reset. The receiver cannot stall: every strobe is a delivered character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_text (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire itdt_pkg::itdt_in_t  request,
    output logic                     busy,
    output logic                     strobe,
    output itdt_pkg::itdt_out_t      result
);
    import itdt_pkg::*;

    logic              v0_reg;
    itdt_dd_t          d0_reg;
    logic              neg;
    logic [STAGES:0]   v;
    itdt_dd_t          d [STAGES+1];
    logic [STAGES+1:0] en;
    logic              ser_ready;

    assign neg = request.is_signed && request.value[WORD_W-1];

    // Each stage advances when the one after it is empty or advancing.
    always_comb
    begin
        en[STAGES+1] = ser_ready;
        for (int i = STAGES; i >= 0; i--) begin
            en[i] = !v[i] || en[i+1];
        end
    end

    assign busy = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en[0])
        begin
            v0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && start)
        begin
            d0_reg.bcd <= '0;
            d0_reg.bin <= neg ? (WORD_W'(0) - request.value) : request.value;
            d0_reg.neg <= neg;
        end
    end

    assign v[0] = v0_reg;
    assign d[0] = d0_reg;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        itdt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[g+1]),
            .in_valid  (v[g]),
            .in_data   (d[g]),
            .out_valid (v[g+1]),
            .out_data  (d[g+1])
        );
    end

    itdt_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v[STAGES]),
        .in_data  (d[STAGES]),
        .ready    (ser_ready),
        .strobe   (strobe),
        .result   (result)
    );

    a_busy_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (v[0] && v[STAGES]))
        else $error("busy while pipeline has room");
    a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> v[0])
        else $error("held word lost while busy");
    a_no_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !busy)
        else $error("busy right after reset");

endmodule

`default_nettype wire

[sim/tb_integer_to_decimal_text.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_decimal_text
// Feeds signed and unsigned words into the decimal text converter and checks
// every character it emits against a behavioral conversion of the same word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_decimal_text;

    import itdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 310;

    logic      clk;
    logic      rst_n;
    logic      start;
    itdt_in_t  request;
    logic      busy;
    logic      strobe;
    itdt_out_t result;

    itdt_in_t  word_queue[$];
    itdt_out_t char_queue[$];
    bit        calm;
    int        errors;
    int        words_sent;
    int        chars_seen;
    int        idle_cycles;
    int        gap;

    integer_to_decimal_text u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Appends the expected characters of one word to the text queue.
    task automatic predict_text(input itdt_in_t w);
        logic [31:0] mag;
        logic [7:0]  digit_chars[$];
        bit          neg;
        neg = w.is_signed && w.value[31];
        mag = neg ? (32'd0 - w.value) : w.value;
        do
        begin
            digit_chars.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (neg)
        begin
            char_queue.push_back('{character: CHAR_MINUS, last: 1'b0});
        end
        foreach (digit_chars[i])
        begin
            char_queue.push_back('{character: digit_chars[i],
                                   last: (i == digit_chars.size() - 1)});
        end
    endtask

    task automatic add_word(input logic [31:0] v, input logic s);
        itdt_in_t w;
        w.value     = v;
        w.is_signed = s;
        word_queue.push_back(w);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int          digits;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v = v;
            1:
            begin
                digits = $urandom_range(1, 9);
                v = $urandom % (10 ** digits);
            end
            2: v = 32'd0 - ($urandom % 1000);
            default: v = v >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // Driver: one word offered at a time, with random gaps until the calm phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
            gap     <= 0;
        end
        else if (start && !busy)
        begin
            predict_text(request);
            words_sent <= words_sent + 1;
            if (word_queue.size() != 0 && (calm || $urandom_range(0, 3) != 0))
            begin
                request <= word_queue.pop_front();
            end
            else
            begin
                start <= 1'b0;
                gap   <= calm ? 0 : $urandom_range(1, 5);
            end
        end
        else if (!start)
        begin
            if (gap > 0)
            begin
                gap <= gap - 1;
            end
            else if (word_queue.size() != 0)
            begin
                start   <= 1'b1;
                request <= word_queue.pop_front();
            end
        end
    end

    // Monitor: every strobe carries one character.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            chars_seen <= chars_seen + 1;
            if (char_queue.size() == 0)
            begin
                $error("unexpected character %h last %b", result.character, result.last);
                errors <= errors + 1;
            end
            else
            begin
                itdt_out_t exp_char;
                exp_char = char_queue.pop_front();
                if (result.character !== exp_char.character)
                begin
                    $error("character: expected %h actual %h",
                           exp_char.character, result.character);
                    errors <= errors + 1;
                end
                if (result.last !== exp_char.last)
                begin
                    $error("last: expected %b actual %b", exp_char.last, result.last);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_integer_to_decimal_text: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        errors        = 0;
        words_sent    = 0;
        chars_seen    = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        start         = 1'b0;
        request       = '0;
        rst_n         = 1'b0;

        // Extremes, zero both ways, and the most negative signed value.
        add_word(32'd0, 1'b0);
        add_word(32'd0, 1'b1);
        add_word(32'h8000_0000, 1'b1);
        add_word(32'h8000_0000, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b1);
        add_word(32'h7FFF_FFFF, 1'b1);
        add_word(32'h7FFF_FFFF, 1'b0);
        add_word(32'd9, 1'b0);
        add_word(32'd10, 1'b1);
        add_word(32'd999_999_999, 1'b0);
        add_word(32'd1_000_000_000, 1'b1);
        add_word(32'hFFFF_FFF6, 1'b1);
        add_word(32'h5555_5555, 1'b0);
        add_word(32'hAAAA_AAAA, 1'b1);
        add_word(32'd1, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 60)
            begin
                wait (word_queue.size() == 0);
                calm = 1'b1;
            end
            add_word(random_value(), 1'($urandom_range(0, 1)));
        end

        wait (word_queue.size() == 0 && !start);
        wait (char_queue.size() == 0);
        repeat (20) @(posedge clk);

        $display("Converted %0d words into %0d characters, signed and unsigned.",
                 words_sent, chars_seen);
        if (errors == 0 && char_queue.size() == 0)
        begin
            $display("tb_integer_to_decimal_text: PASS");
        end
        else
        begin
            $display("tb_integer_to_decimal_text: FAIL");
        end
        $finish;
    end

endmodule
